// ===== hdl/mitd_pkg.sv =====
// ----------------------------------------------------------------------------
// mitd_pkg: shared types and constants of the multi input time debouncer
// Channel count, field widths, register codes and the structs that pass
// between the configuration, evaluation and result serializer blocks.
// ----------------------------------------------------------------------------
package mitd_pkg;

   // channels that take part; the datapath is always NUM_CH wide
   localparam int CHANNELS   = 16;
   localparam int NUM_CH     = 16;
   localparam int CH_W       = 4;
   localparam int TIME_W     = 32;
   localparam int DEB_W      = 16;
   localparam int CNT_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int DEB_GROUPS = 4;
   localparam int DEB_PER_GR = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INVERT_MASK = 3'd0,
      REG_DEBOUNCE_0  = 3'd1,
      REG_DEBOUNCE_1  = 3'd2,
      REG_DEBOUNCE_2  = 3'd3,
      REG_DEBOUNCE_3  = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [NUM_CH-1:0]            invert;
      logic [NUM_CH-1:0][DEB_W-1:0] debounce;
   } cfg_type;

   // one tick's stable changes: mask of changed channels, map and count before them
   typedef struct packed {
      logic              valid;
      logic [NUM_CH-1:0] mask;
      logic [NUM_CH-1:0] map;
      logic [CNT_W-1:0]  count;
   } rec_type;

   typedef struct packed {
      logic [NUM_CH-1:0] stable;
      logic [CNT_W-1:0]  counter;
   } status_type;

endpackage

// ===== hdl/mitd_csr.sv =====
// ----------------------------------------------------------------------------
// mitd_csr: configuration registers
// Holds the invert mask and the four packed debounce time registers.
// ----------------------------------------------------------------------------
module mitd_csr
   import mitd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg
);

   logic [NUM_CH-1:0]     invert_ff;
   logic [NUM_CH-1:0]     invert_in;
   logic [CSR_DATA_W-1:0] debounce_ff [DEB_GROUPS];
   logic [CSR_DATA_W-1:0] debounce_in [DEB_GROUPS];

   assign csr_ready = 1'b1;

   always_comb begin
      invert_in   = invert_ff;
      debounce_in = debounce_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_INVERT_MASK: invert_in      = csr_data[NUM_CH-1:0];
            REG_DEBOUNCE_0:  debounce_in[0] = csr_data;
            REG_DEBOUNCE_1:  debounce_in[1] = csr_data;
            REG_DEBOUNCE_2:  debounce_in[2] = csr_data;
            REG_DEBOUNCE_3:  debounce_in[3] = csr_data;
            default: ; // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invert_ff <= '0;
         for (int g = 0; g < DEB_GROUPS; g++) begin
            debounce_ff[g] <= '0;
         end
      end else begin
         invert_ff   <= invert_in;
         debounce_ff <= debounce_in;
      end
   end

   always_comb begin
      cfg.invert = invert_ff;
      for (int g = 0; g < DEB_GROUPS; g++) begin
         for (int k = 0; k < DEB_PER_GR; k++) begin
            cfg.debounce[g*DEB_PER_GR+k] = debounce_ff[g][k*DEB_W +: DEB_W];
         end
      end
   end

endmodule

// ===== hdl/mitd_eval.sv =====
// ----------------------------------------------------------------------------
// mitd_eval: per tick channel evaluation
// Compares each channel with its last sample and its debounce time and
// updates the raw, stable, timestamp and change counter state.
// ----------------------------------------------------------------------------
module mitd_eval
   import mitd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_CH-1:0] in_levels,
   input  logic [TIME_W-1:0] in_now,
   input  cfg_type           cfg,
   input  logic              rec_ready,
   output logic              take,
   output rec_type           rec,
   output status_type        status
);

   logic [NUM_CH-1:0] raw_ff;
   logic [NUM_CH-1:0] raw_in;
   logic [NUM_CH-1:0] stable_ff;
   logic [NUM_CH-1:0] stable_in;
   logic [TIME_W-1:0] ttime_ff [NUM_CH];
   logic [TIME_W-1:0] ttime_in [NUM_CH];
   logic [CNT_W-1:0]  counter_ff;
   logic [CNT_W-1:0]  counter_in;

   logic [NUM_CH-1:0] active;
   logic [NUM_CH-1:0] raw_chg;
   logic [NUM_CH-1:0] chg;

   // nibble sums first, then the four nibble sums are added up
   function automatic logic [4:0] popcount16(input logic [NUM_CH-1:0] v);
      logic [2:0] nib [4];
      logic [4:0] sum;
      sum = '0;
      for (int n = 0; n < 4; n++) begin
         nib[n] = {2'b00, v[4*n]} + {2'b00, v[4*n+1]} + {2'b00, v[4*n+2]}
                  + {2'b00, v[4*n+3]};
      end
      for (int n = 0; n < 4; n++) begin
         sum = sum + {2'b00, nib[n]};
      end
      return sum;
   endfunction

   always_comb begin
      logic [TIME_W-1:0] elapsed;
      logic [DEB_W-1:0]  deb_eff;
      elapsed = '0;
      deb_eff = '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (ch < CHANNELS) begin
            active[ch]  = ~in_levels[ch] ^ cfg.invert[ch];
            raw_chg[ch] = raw_ff[ch] != active[ch];
            deb_eff     = (cfg.debounce[ch] == '0) ? DEB_W'(1) : cfg.debounce[ch];
            elapsed     = in_now - ttime_ff[ch];
            // a fresh edge restarts the timer, so it cannot be due this tick
            chg[ch]     = !raw_chg[ch] && (elapsed >= {{(TIME_W-DEB_W){1'b0}}, deb_eff})
                          && (stable_ff[ch] != active[ch]);
         end else begin
            active[ch]  = 1'b0;
            raw_chg[ch] = 1'b0;
            chg[ch]     = 1'b0;
         end
      end
   end

   assign take = in_valid && ((chg == '0) || rec_ready);

   always_comb begin
      raw_in     = raw_ff;
      stable_in  = stable_ff;
      ttime_in   = ttime_ff;
      counter_in = counter_ff;
      if (take) begin
         raw_in     = active;
         stable_in  = stable_ff ^ chg;
         counter_in = counter_ff + CNT_W'(popcount16(chg));
         for (int ch = 0; ch < NUM_CH; ch++) begin
            if (raw_chg[ch]) begin
               ttime_in[ch] = in_now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff     <= '0;
         stable_ff  <= '0;
         counter_ff <= '0;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            ttime_ff[ch] <= '0;
         end
      end else begin
         raw_ff     <= raw_in;
         stable_ff  <= stable_in;
         counter_ff <= counter_in;
         ttime_ff   <= ttime_in;
      end
   end

   assign rec.valid      = take && (chg != '0);
   assign rec.mask       = chg;
   assign rec.map        = stable_ff;
   assign rec.count      = counter_ff;
   assign status.stable  = stable_ff;
   assign status.counter = counter_ff;

endmodule

// ===== hdl/mitd_serial.sv =====
// ----------------------------------------------------------------------------
// mitd_serial: change result serializer
// Holds one tick's change mask and emits one result per changed channel,
// lowest channel first, into the result register.
// ----------------------------------------------------------------------------
module mitd_serial
   import mitd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rec_type           rec,
   output logic              rec_ready,
   output rec_type           held,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CH_W-1:0]   rsp_chan,
   output logic              rsp_level,
   output logic [NUM_CH-1:0] rsp_map,
   output logic [CNT_W-1:0]  rsp_count,
   output logic              rsp_last
);

   rec_type           held_ff;
   rec_type           held_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CH_W-1:0]   chan_ff;
   logic              level_ff;
   logic [NUM_CH-1:0] map_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              last_ff;

   logic [NUM_CH-1:0] lsb;
   logic [NUM_CH-1:0] rest;
   logic [NUM_CH-1:0] map_next;
   logic [CNT_W-1:0]  count_next;
   logic [CH_W-1:0]   chan;
   logic              emit;

   assign lsb        = held_ff.mask & (~held_ff.mask + NUM_CH'(1));
   assign rest       = held_ff.mask & ~lsb;
   assign map_next   = held_ff.map ^ lsb;
   assign count_next = held_ff.count + CNT_W'(1);

   always_comb begin
      chan = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         chan = chan | (lsb[i] ? CH_W'(i) : CH_W'(0));
      end
   end

   assign emit      = (held_ff.mask != '0) && (!rsp_valid_ff || rsp_ready);
   assign rec_ready = (held_ff.mask == '0) || (emit && (rest == '0));

   always_comb begin
      held_in = held_ff;
      if (rec.valid) begin
         held_in = rec;
      end else if (emit) begin
         held_in.mask  = rest;
         held_in.map   = map_next;
         held_in.count = count_next;
         held_in.valid = rest != '0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         chan_ff  <= chan;
         level_ff <= |(map_next & lsb);
         map_ff   <= map_next;
         count_ff <= count_next;
         last_ff  <= rest == '0;
      end
   end

   assign held      = held_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_chan  = chan_ff;
   assign rsp_level = level_ff;
   assign rsp_map   = map_ff;
   assign rsp_count = count_ff;
   assign rsp_last  = last_ff;

endmodule

// ===== hdl/multi_input_time_debouncer.sv =====
// ----------------------------------------------------------------------------
// multi_input_time_debouncer: sixteen channel timestamp debouncer
// Path: a tick passes the input register, the serializer's held register, then the result register.
// Throughput: one tick per cycle while ticks cause no change; a tick with n
// stable changes holds the serializer for its n results, one per unstalled cycle.
// Reset: synchronous active high, clears config, channel state and counter.
// ----------------------------------------------------------------------------
module multi_input_time_debouncer
   import mitd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // tick channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // raw_levels[15:0], now_ms[47:16]
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // channel[3:0], new_level[4],
                                              // active_map[20:5], change_count[28:21],
                                              // zero[31:29]
   output logic                  rsp_tlast,
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // input register
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [NUM_CH-1:0] levels_ff;
   logic [TIME_W-1:0] now_ff;

   cfg_type           cfg;
   rec_type           rec;
   rec_type           held;
   status_type        status;
   logic              take;
   logic              rec_ready;

   logic [CH_W-1:0]   out_chan;
   logic              out_level;
   logic [NUM_CH-1:0] out_map;
   logic [CNT_W-1:0]  out_count;

   mitd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // the input register frees up as soon as its tick is evaluated
   assign req_tready  = !in_valid_ff || take;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         levels_ff <= req_tdata[15:0];
         now_ff    <= req_tdata[47:16];
      end
   end

   // evaluation; a tick with changes waits until the serializer has room
   mitd_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_levels (levels_ff),
      .in_now    (now_ff),
      .cfg       (cfg),
      .rec_ready (rec_ready),
      .take      (take),
      .rec       (rec),
      .status    (status)
   );

   // one result per changed channel, lowest first
   mitd_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .rec       (rec),
      .rec_ready (rec_ready),
      .held      (held),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_chan  (out_chan),
      .rsp_level (out_level),
      .rsp_map   (out_map),
      .rsp_count (out_count),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_count, out_map, out_level, out_chan};

   // counts still queued in the serializer plus its base count track the counter
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(held.count + CNT_W'($countones(held.mask))) == status.counter)
      else $error("serializer count out of step with change counter");

   // stable map only moves when a tick is evaluated
   a_stable_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(status.stable))
      else $error("stable map changed without a tick");

   // reported level agrees with the reported map
   a_level_map: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_level == out_map[out_chan]))
      else $error("new level disagrees with active map");

endmodule

// ===== dv/multi_input_time_debouncer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_input_time_debouncer_test: self-checking bench for the debouncer
// Drives polling ticks and register writes through the stream and csr
// channels, predicts every stable change in a scoreboard class and checks
// the result stream in order, with random gaps on the tick side and random stalls on the result side.
// ----------------------------------------------------------------------------
module multi_input_time_debouncer_test;
   import mitd_pkg::*;

   // register indexes past the last debounce group, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;
   // idle cycles after the last result before a register write or the end
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_TICKS  = 50;

   // one expected stable change
   typedef struct packed {
      logic [CH_W-1:0]   channel;
      logic              level;
      logic [NUM_CH-1:0] map;
      logic [CNT_W-1:0]  count;
      logic              last;
   } change_type;

   // ---------------------------------------------------------------------
   // scoreboard: own copy of config and channel state, queue of changes
   // ---------------------------------------------------------------------
   class debounce_scoreboard;
      bit [NUM_CH-1:0]     invert_sel;
      bit [CSR_DATA_W-1:0] hold_regs [DEB_GROUPS];
      bit [NUM_CH-1:0]     raw_map;
      bit [NUM_CH-1:0]     stable_map;
      bit [TIME_W-1:0]     stamp [NUM_CH];
      bit [CNT_W-1:0]      change_ctr;
      change_type          due_q [$];
      int                  mismatches;
      int                  ticks;
      int                  results;
      int                  writes;

      function new();
         invert_sel = '0;
         raw_map    = '0;
         stable_map = '0;
         change_ctr = '0;
         mismatches = 0;
         ticks      = 0;
         results    = 0;
         writes     = 0;
         foreach (hold_regs[i]) hold_regs[i] = '0;
         foreach (stamp[i]) stamp[i] = '0;
      endfunction

      // accepted csr transaction
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         writes++;
         if (idx == REG_INVERT_MASK)
            invert_sel = val[NUM_CH-1:0];
         else if (idx <= REG_DEBOUNCE_3)
            hold_regs[idx - REG_DEBOUNCE_0] = val;
      endfunction

      // accepted tick: update channel state and queue the changes it causes
      function void note_tick(logic [NUM_CH-1:0] levels, logic [TIME_W-1:0] now);
         bit              active;
         bit [TIME_W-1:0] hold;
         int              first;
         change_type      rec;
         ticks++;
         first = due_q.size();
         for (int ch = 0; ch < CHANNELS; ch++) begin
            // low pin means active unless the mask bit flips it
            active = ~levels[ch] ^ invert_sel[ch];
            if (raw_map[ch] != active) begin
               raw_map[ch] = active;
               stamp[ch]   = now;
            end
            hold = TIME_W'(hold_regs[ch / DEB_PER_GR][(ch % DEB_PER_GR) * DEB_W +: DEB_W]);
            if (hold == 0)
               hold = 1;
            if (((now - stamp[ch]) >= hold) && (stable_map[ch] != active)) begin
               stable_map[ch] = active;
               change_ctr++;
               rec.channel = CH_W'(ch);
               rec.level   = active;
               rec.map     = stable_map;
               rec.count   = change_ctr;
               rec.last    = 1'b0;
               due_q.push_back(rec);
            end
         end
         // flag the final change of this tick
         if (due_q.size() > first) begin
            rec = due_q.pop_back();
            rec.last = 1'b1;
            due_q.push_back(rec);
         end
      endfunction

      // accepted result transaction against the oldest expectation
      function void check_result(logic [31:0] data, logic last_flag);
         change_type want;
         results++;
         if (due_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with nothing expected: data=%h last=%b",
                        $realtime, data, last_flag);
            return;
         end
         want = due_q.pop_front();
         if (data[3:0] !== want.channel || data[4] !== want.level ||
             data[20:5] !== want.map || data[28:21] !== want.count ||
             data[31:29] !== 3'b000 || last_flag !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: change mismatch: exp ch=%0d lvl=%b map=%h cnt=%0d last=%b",
                         " pad=0 | act ch=%0d lvl=%b map=%h cnt=%0d last=%b pad=%b"},
                        $realtime, want.channel, want.level, want.map, want.count,
                        want.last, data[3:0], data[4], data[20:5], data[28:21],
                        last_flag, data[31:29]);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // clock, reset and block signals, all driven ones known from time zero
   // ---------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata  = '0;   // raw_levels[15:0], now_ms[47:16]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // channel[3:0], new_level[4],
                                             // active_map[20:5], change_count[28:21]
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   debounce_scoreboard    sb;
   bit                    steady = 1'b0;    // no gaps and no new stalls while set
   int                    stall_left = 0;
   logic [NUM_CH-1:0]     pins;             // current pin picture of the random part
   logic [TIME_W-1:0]     clk_ms;           // current tick time of the random part

   always #5 clock = ~clock;

   multi_input_time_debouncer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------------
   // gap and stall lengths: mostly short, a few long
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 65)
         return 0;
      else if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_stall();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // four random debounce times packed into one register, each up to top
   function automatic logic [CSR_DATA_W-1:0] pack_holds(int top);
      logic [CSR_DATA_W-1:0] v;
      for (int i = 0; i < DEB_PER_GR; i++)
         v[i * DEB_W +: DEB_W] = DEB_W'($urandom_range(0, top));
      return v;
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 99) < 25)
            stall_left = pick_stall();
      end
   end

   // result monitor, values sampled as they stood at the edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast);
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // one tick transaction; valid stays high when the next one follows at once
   task automatic send_tick(input logic [NUM_CH-1:0] levels, input logic [TIME_W-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {now, levels};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(levels, now);
   endtask

   // one csr transaction; the caller lowers valid after the last one
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   // full register set, plus a write to an unused index that must be dropped
   task automatic write_settings(input logic [NUM_CH-1:0] inv,
                                 input logic [CSR_DATA_W-1:0] d0, input logic [CSR_DATA_W-1:0] d1,
                                 input logic [CSR_DATA_W-1:0] d2, input logic [CSR_DATA_W-1:0] d3);
      write_csr(REG_INVERT_MASK, {48'h0, inv});
      write_csr(REG_DEBOUNCE_0, d0);
      write_csr(REG_DEBOUNCE_1, d1);
      write_csr(REG_DEBOUNCE_2, d2);
      write_csr(REG_DEBOUNCE_3, d3);
      write_csr(CSR_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // stop ticks, wait for every expected change, then let the pipe settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.due_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random ticks: mostly bounce and settle sequences, some jumps and noise
   task automatic random_ticks(input int count, input int step_max);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            // a pin or two bounce, time moves a little
            pins[$urandom_range(0, NUM_CH - 1)] ^= 1'b1;
            if ($urandom_range(0, 1))
               pins[$urandom_range(0, NUM_CH - 1)] ^= 1'b1;
            clk_ms += $urandom_range(0, step_max);
         end else if (r < 80) begin
            // pins hold, time runs on so levels settle
            clk_ms += $urandom_range(0, step_max * 3);
         end else if (r < 90) begin
            // long jump, reaches the longest debounce times
            clk_ms += $urandom_range(0, 140000);
         end else if (r < 95) begin
            pins   = NUM_CH'($urandom);
            clk_ms = $urandom;
         end else begin
            // pins jump at random, time steps back a little
            pins   = NUM_CH'($urandom);
            clk_ms -= $urandom_range(0, 3);
         end
         send_tick(pins, clk_ms);
      end
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset values written back explicitly: no inversion, zero acts as one
      write_settings(16'h0000, '0, '0, '0, '0);
      send_tick(16'hFFFF, 32'd0);          // nothing active
      send_tick(16'h0000, 32'd0);          // all go raw active, not yet stable
      send_tick(16'h0000, 32'd1);          // one ms later: all sixteen report
      send_tick(16'hFFFF, 32'hFFFF_FFFF);  // all release at top of time range
      send_tick(16'hFFFF, 32'd0);          // wrap counts as one ms: sixteen again
      send_tick(16'h5555, 32'd10);
      send_tick(16'h5555, 32'd11);         // odd channels become stable
      send_tick(16'hAAAA, 32'd11);         // bounce
      send_tick(16'h5555, 32'd12);         // back before the hold ran out
      send_tick(16'h5555, 32'd13);         // no change expected

      // longest debounce everywhere with inverted sense
      wait_idle();
      write_settings(16'hFFFF, '1, '1, '1, '1);
      send_tick(16'hFFFF, 32'd100);
      send_tick(16'hFFFF, 32'd100 + 32'd65534);  // one short of the hold
      send_tick(16'hFFFF, 32'd100 + 32'd65535);  // hold reached
      send_tick(16'h0000, 32'd5);
      send_tick(16'h0000, 32'd4);                // backwards in time wraps far

      // per channel hold times of 0..3, half the channels inverted
      wait_idle();
      write_settings(16'h0F0F, 64'h0003_0002_0001_0000, 64'h0000_0001_0002_0003,
                     64'h0003_0002_0001_0000, 64'h0000_0001_0002_0003);
      send_tick(16'h0000, 32'd1000);
      send_tick(16'h0000, 32'd1001);
      send_tick(16'h0000, 32'd1002);
      send_tick(16'hFFFF, 32'd1003);
      send_tick(16'hFFFF, 32'd1006);

      // random phase: zero debounce, time runs across the 32-bit wrap
      wait_idle();
      write_settings(16'h0000, '0, '0, '0, '0);
      pins   = NUM_CH'($urandom);
      clk_ms = 32'hFFFF_FFC0;
      random_ticks(RANDOM_TICKS, 3);

      // random phase: short random holds, random inversion, no idling
      wait_idle();
      steady = 1'b1;
      write_settings(NUM_CH'($urandom), pack_holds(6), pack_holds(6), pack_holds(6),
                     pack_holds(6));
      random_ticks(RANDOM_TICKS, 4);
      steady = 1'b0;

      // random phase: all inverted, extreme and short holds mixed
      wait_idle();
      write_settings(16'hFFFF, 64'hFFFF_0000_0001_0005, pack_holds(8), pack_holds(8),
                     {16'hFFFF, 48'(pack_holds(3))});
      clk_ms = $urandom;
      random_ticks(RANDOM_TICKS, 5);

      // random phase: fully random register values
      wait_idle();
      write_settings(NUM_CH'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      random_ticks(RANDOM_TICKS, 4);

      wait_idle();
      $display("run covered %0d ticks, %0d stable change results, %0d register writes",
               sb.ticks, sb.results, sb.writes);
      $display("mismatches: %0d", sb.mismatches);
      if (sb.mismatches == 0)
         $display("multi_input_time_debouncer regression: pass");
      else
         $display("multi_input_time_debouncer regression: fail");
      $finish;
   end

   // watchdog: a hung handshake or lost result ends the run here
   initial begin
      #(20_000_000);
      $display("timeout with %0d changes still expected", sb.due_q.size());
      $display("multi_input_time_debouncer regression: fail");
      $finish;
   end

endmodule
